// ===== hdl/ubt_pkg.sv =====
// shared types and constants for the udp port bind table
// no dependencies; imported by the table top level
`timescale 1ns / 1ps
`default_nettype none

package ubt_pkg;

    localparam int PORT_W  = 16;
    localparam int HID_W   = 4;
    localparam int REQ_W   = 3;
    localparam int ENTRY_W = PORT_W + HID_W;

    localparam int ENTRIES_DEF = 8;

    localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'hF000;

    // configuration register index, taken from paddr[2]
    localparam logic REG_DEFAULT_PORT = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_BIND   = 3'd0,
        REQ_FREE   = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_ALLOC  = 3'd3,
        REQ_SET    = 3'd4
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/udp_port_bind_table.sv =====
// udp port bind table top level: request fsm, entry scan, port allocator, apb registers
// depends on ubt_pkg and ubt_ram
`timescale 1ns / 1ps
`default_nettype none

// Table of ENTRIES bound udp ports, each with a 4-bit handler id, held in one
// ram with a registered read, plus an ephemeral port counter.
// Bind, free and lookup scan the ram from entry 0 and stop at the first match:
// one entry is read per cycle and compared the cycle after, until a match or
// the last entry. Free and lookup of port 0, allocate, set and unused codes
// skip the scan. A stalled output register holds the finished request until
// it is free. One request is in work at a time; the next one is accepted
// while the previous result waits in the output register. Per-entry valid
// bits give an empty table right out of reset, with no clearing pass.
module udp_port_bind_table #(
    parameter int ENTRIES = ubt_pkg::ENTRIES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ubt_pkg::REQ_W-1:0]  req_type,
    input  wire logic [ubt_pkg::PORT_W-1:0] port,
    input  wire logic [ubt_pkg::HID_W-1:0]  handler_id,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            found,
    output logic      [ubt_pkg::HID_W-1:0]  found_handler,
    output logic      [ubt_pkg::PORT_W-1:0] alloc_port,
    output logic                            table_full,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    import ubt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    state_t state_reg, state_next;

    logic [REQ_W-1:0]  req_reg;
    logic [PORT_W-1:0] port_reg;
    logic [HID_W-1:0]  hid_reg;

    logic [CNT_W-1:0]   iss_cnt_reg, iss_cnt_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic              res_found_reg, res_found_next;
    logic [HID_W-1:0]  res_hid_reg, res_hid_next;
    logic [PORT_W-1:0] res_alloc_reg, res_alloc_next;
    logic              res_full_reg, res_full_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [HID_W-1:0]  found_handler_reg;
    logic [PORT_W-1:0] alloc_port_reg;
    logic              table_full_reg;

    logic [PORT_W-1:0] next_port_reg, next_port_next;
    logic [PORT_W-1:0] default_port_reg;

    logic               accept;
    logic               needs_scan;
    logic               issue;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [PORT_W-1:0]  ent_port;
    logic [HID_W-1:0]   ent_hid;
    logic [PORT_W-1:0]  key;
    logic               hit;
    logic               last;
    logic               scan_end;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               out_free;
    logic [PORT_W-1:0]  port_dec;
    logic               cfg_wr;

    ubt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(chk_idx_reg),
        .wdata(ram_wdata),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign needs_scan = (req_type == REQ_BIND)
        || (((req_type == REQ_FREE) || (req_type == REQ_LOOKUP)) && (port != '0));

    // entry compare, an entry never written reads as empty
    assign ent_port = valid_reg[chk_idx_reg] ? rd_data[ENTRY_W-1:HID_W] : '0;
    assign ent_hid  = valid_reg[chk_idx_reg] ? rd_data[HID_W-1:0] : '0;
    assign key      = (req_reg == REQ_BIND) ? '0 : port_reg;
    assign hit      = chk_vld_reg && (ent_port == key);
    assign last     = (chk_idx_reg == IDX_W'(ENTRIES - 1));
    assign scan_end = chk_vld_reg && (hit || last);

    assign rd_addr = iss_cnt_reg[IDX_W-1:0];
    assign issue   = (state_reg == ST_SCAN) && (iss_cnt_reg < CNT_W'(ENTRIES)) && !scan_end;

    assign ram_we = (state_reg == ST_SCAN) && hit
        && ((req_reg == REQ_BIND) || (req_reg == REQ_FREE));
    // free clears the port and keeps the handler
    assign ram_wdata = (req_reg == REQ_BIND) ? {port_reg, hid_reg} : {{PORT_W{1'b0}}, ent_hid};

    assign port_dec = next_port_reg - 16'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // scan control, results and counter
    always_comb
    begin
        iss_cnt_next   = iss_cnt_reg;
        chk_vld_next   = issue;
        valid_next     = valid_reg;
        res_found_next = res_found_reg;
        res_hid_next   = res_hid_reg;
        res_alloc_next = res_alloc_reg;
        res_full_next  = res_full_reg;
        next_port_next = next_port_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (accept)
        begin
            iss_cnt_next   = '0;
            res_found_next = 1'b0;
            res_hid_next   = '0;
            res_alloc_next = '0;
            res_full_next  = 1'b0;
            unique case (req_type)
                REQ_ALLOC:
                begin
                    res_alloc_next = next_port_reg;
                    next_port_next = (port_dec[PORT_W-1:8] == '0) ? default_port_reg : port_dec;
                end
                REQ_SET:
                begin
                    next_port_next = port;
                end
                default:
                begin
                    next_port_next = next_port_reg;
                end
            endcase
        end

        if (issue)
        begin
            iss_cnt_next = iss_cnt_reg + CNT_W'(1);
        end

        if (ram_we)
        begin
            valid_next[chk_idx_reg] = 1'b1;
        end

        if ((state_reg == ST_SCAN) && scan_end)
        begin
            res_found_next = hit;
            res_hid_next   = ((req_reg == REQ_LOOKUP) && hit) ? ent_hid : '0;
            res_full_next  = (req_reg == REQ_BIND) && !hit;
        end

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_cnt_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            next_port_reg <= DEFAULT_PORT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            iss_cnt_reg   <= iss_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            next_port_reg <= next_port_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            port_reg <= port;
            hid_reg  <= handler_id;
        end
        if (issue)
        begin
            chk_idx_reg <= rd_addr;
        end
        res_found_reg <= res_found_next;
        res_hid_reg   <= res_hid_next;
        res_alloc_reg <= res_alloc_next;
        res_full_reg  <= res_full_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            found_reg         <= res_found_reg;
            found_handler_reg <= res_hid_reg;
            alloc_port_reg    <= res_alloc_reg;
            table_full_reg    <= res_full_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign found_handler = found_handler_reg;
    assign alloc_port    = alloc_port_reg;
    assign table_full    = table_full_reg;

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_PORT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_port_reg <= DEFAULT_PORT_RST;
        end
        else if (cfg_wr)
        begin
            default_port_reg <= pwdata[PORT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEFAULT_PORT) ? {16'b0, default_port_reg} : 32'b0;

    // checks
    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SCAN) && chk_vld_reg)
        else $error("table write outside a scan compare");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_cnt_reg <= CNT_W'(ENTRIES)))
        else $error("scan read counter past table end");

    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && table_full_reg))
        else $error("found and table_full both set");

    a_hid_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (found_handler_reg != '0) |-> found_reg)
        else $error("handler reported without a hit");

    a_alloc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (alloc_port_reg != '0) |-> !found_reg && !table_full_reg)
        else $error("allocated port mixed with table result");

endmodule

`default_nettype wire

// ===== hdl/ubt_ram.sv =====
// generic single write port, single read port ram with registered read
// no package dependency; width and depth set by the instantiating module
`timescale 1ns / 1ps
`default_nettype none

module ubt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
